// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sitr_pkg.sv =====
`timescale 1ns / 1ps

package sitr_pkg;

  localparam int VALUE_W       = 64;
  localparam int RADIX_W       = 8;
  localparam int CODE_W        = 7;
  localparam int BIT_CNT_W     = 6;
  localparam int DEF_MAX_CHARS = 15;
  localparam int RADIX_MIN     = 2;
  localparam int RADIX_MAX     = 224;
  localparam int ALPHA_LEN     = 91;
  localparam int PUNCT_LEN     = 29;

  localparam logic [CODE_W-1:0] MINUS_CODE = 7'd45;
  localparam logic [CODE_W-1:0] NULL_CODE  = 7'd0;

  typedef struct packed {
    logic              in_alphabet;
    logic [CODE_W-1:0] code;
  } sym_t;

  localparam logic [CODE_W-1:0] PUNCT [PUNCT_LEN] = '{
    7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
    7'd45, 7'd46, 7'd47, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64,
    7'd91, 7'd93, 7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126
  };

  // 0-9, A-Z, a-z, then punctuation; anything beyond is flagged.
  function automatic sym_t alpha_code(input logic [RADIX_W-1:0] d);
    sym_t s;
    logic [4:0] idx;
    s   = '{in_alphabet: 1'b1, code: NULL_CODE};
    idx = 5'(d - 8'd62);
    if (d < 8'd10) begin
      s.code = 7'(d + 8'd48);
    end else if (d < 8'd36) begin
      s.code = 7'(d + 8'd55);
    end else if (d < 8'd62) begin
      s.code = 7'(d + 8'd61);
    end else if (d < 8'(ALPHA_LEN)) begin
      s.code = PUNCT[idx];
    end else begin
      s.in_alphabet = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/sitr_in_if.sv =====
`timescale 1ns / 1ps

interface sitr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitr_pkg::VALUE_W-1:0] value;
  logic        [sitr_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

// ===== hw/rtl/sitr_out_if.sv =====
`timescale 1ns / 1ps

interface sitr_out_if;
  logic                        valid;
  logic                        ready;
  logic [sitr_pkg::CODE_W-1:0] char_code;
  logic                        in_alphabet;
  logic                        last;
  logic                        empty_res;

  modport source (output valid, output char_code, output in_alphabet, output last,
                  output empty_res, input ready);
  modport sink   (input valid, input char_code, input in_alphabet, input last,
                  input empty_res, output ready);
endinterface

// ===== hw/rtl/sitr_bitdiv.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sitr_bitdiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sitr_pkg::VALUE_W-1:0]   dividend,
  input  logic [sitr_pkg::RADIX_W-1:0]   divisor,
  output logic                           done,
  output logic [sitr_pkg::VALUE_W-1:0]   quotient,
  output logic [sitr_pkg::RADIX_W-1:0]   remainder
);

  localparam int VW = sitr_pkg::VALUE_W;
  localparam int RW = sitr_pkg::RADIX_W;
  localparam int CW = sitr_pkg::BIT_CNT_W;

  logic [VW-1:0] q;
  logic [RW-1:0] r;
  logic [RW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [RW:0]   trial;
  logic          ge;
  logic [RW:0]   diff;
  logic [RW-1:0] r_next;
  logic [VW-1:0] q_next;

  always_comb begin
    trial  = {r, q[VW-1]};
    ge     = trial >= {1'b0, d};
    diff   = trial - {1'b0, d};
    r_next = ge ? diff[RW-1:0] : trial[RW-1:0];
    q_next = {q[VW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

// ===== hw/rtl/signed_integer_to_radix_text_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Handshake
// in_ch     in   value[63:0] signed, radix[7:0]           valid/ready
// out_ch    out  char_code[6:0], in_alphabet, last,       valid/ready
//                empty_res
//
// One value at a time. Each digit comes from a full 64-bit division in the bit-serial
// divider; up to MAX_CHARS digits, then one character out per cycle while the output
// is not stalled. Bad radix: one empty transaction the cycle after acceptance.
// Synchronous active-high reset clears the control state only.
// Output stalls hold the character register; input is taken only when idle
// and the output register is free.
module signed_integer_to_radix_text_unit #(
  parameter int MAX_CHARS = sitr_pkg::DEF_MAX_CHARS
) (
  input  logic              clk,
  input  logic              rst,
  sitr_in_if.sink           in_ch,
  sitr_out_if.source        out_ch
);

  localparam int VW    = sitr_pkg::VALUE_W;
  localparam int RW    = sitr_pkg::RADIX_W;
  localparam int KW    = sitr_pkg::CODE_W;
  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t           state;
  logic [RW-1:0]    base;
  logic             neg;
  logic             sign_pend;
  logic [CNT_W-1:0] nd;
  logic [CNT_W-1:0] n;
  logic [RW-1:0]    stk [MAX_CHARS];

  logic             ovalid;
  logic [KW-1:0]    ocode;
  logic             oinal;
  logic             olast;
  logic             oempty;

  logic             in_acc;
  logic             radix_ok;
  logic [VW-1:0]    vu;
  logic [VW-1:0]    mag;
  logic             out_free;
  logic             div_start;
  logic [VW-1:0]    div_dividend;
  logic [RW-1:0]    div_divisor;
  logic             div_done;
  logic [VW-1:0]    div_q;
  logic [RW-1:0]    div_r;
  logic [CNT_W-1:0] nd_next;
  logic             more;
  logic             push;
  logic             pop;
  logic             dig_last;
  sitr_pkg::sym_t   sym;

  always_comb begin
    out_free    = !ovalid || out_ch.ready;
    in_ch.ready = (state == IDLE) && out_free;
    in_acc      = in_ch.valid && in_ch.ready;
    radix_ok    = (in_ch.radix >= RW'(sitr_pkg::RADIX_MIN)) &&
                  (in_ch.radix <= RW'(sitr_pkg::RADIX_MAX));
    vu          = in_ch.value;
    mag         = vu[VW-1] ? (VW'(0) - vu) : vu;
    nd_next     = nd + 1'b1;
    more        = (div_q != '0) && (nd_next != CNT_W'(MAX_CHARS));
    push        = (state == DIVIDE) && div_done;
    pop         = (state == EMIT) && out_free && !sign_pend;
    dig_last    = (nd == CNT_W'(1)) || (n == CNT_W'(MAX_CHARS - 1));
    sym         = sitr_pkg::alpha_code(stk[0]);
    div_start   = (in_acc && radix_ok) || (push && more);
    div_dividend = (state == IDLE) ? mag : div_q;
    div_divisor  = (state == IDLE) ? in_ch.radix : base;
  end

  sitr_bitdiv u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ovalid    <= 1'b0;
      sign_pend <= 1'b0;
      nd        <= '0;
      n         <= '0;
    end else begin
      if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            if (radix_ok) begin
              base  <= in_ch.radix;
              neg   <= vu[VW-1];
              nd    <= '0;
              state <= DIVIDE;
            end else begin
              ovalid <= 1'b1;
              ocode  <= sitr_pkg::NULL_CODE;
              oinal  <= 1'b0;
              olast  <= 1'b1;
              oempty <= 1'b1;
            end
          end
        end
        DIVIDE: begin
          if (div_done) begin
            nd <= nd_next;
            if (!more) begin
              sign_pend <= neg;
              n         <= '0;
              state     <= EMIT;
            end
          end
        end
        EMIT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            oempty <= 1'b0;
            n      <= n + 1'b1;
            if (sign_pend) begin
              sign_pend <= 1'b0;
              ocode     <= sitr_pkg::MINUS_CODE;
              oinal     <= 1'b1;
              olast     <= 1'b0;
            end else begin
              ocode <= sym.code;
              oinal <= sym.in_alphabet;
              olast <= dig_last;
              nd    <= nd - 1'b1;
              if (dig_last) begin
                state <= IDLE;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Digit stack: push at the top during division, pop from the top on output.
  always_ff @(posedge clk) begin
    if (push) begin
      stk[0] <= div_r;
      for (int i = 1; i < MAX_CHARS; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.char_code   = ocode;
  assign out_ch.in_alphabet = oinal;
  assign out_ch.last        = olast;
  assign out_ch.empty_res   = oempty;

endmodule

// ===== hw/rtl/sitr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sitr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [sitr_pkg::RADIX_W-1:0] radix,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sitr_pkg::CODE_W-1:0] char_code,
  input logic                        in_alphabet,
  input logic                        last,
  input logic                        empty_res
);

  logic bad_radix;
  logic out_stall;
  logic empty_shape;

  assign bad_radix   = (radix < sitr_pkg::RADIX_W'(sitr_pkg::RADIX_MIN)) ||
                       (radix > sitr_pkg::RADIX_W'(sitr_pkg::RADIX_MAX));
  assign out_stall   = out_valid && !out_ready;
  assign empty_shape = last && (char_code == sitr_pkg::NULL_CODE) && !in_alphabet;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(char_code) && $stable(last))
  `ASSERT_SAME(a_empty_shape, clk, rst, out_valid && empty_res, empty_shape)
  `ASSERT_SAME(a_flag_null, clk, rst, out_valid && !in_alphabet, char_code == sitr_pkg::NULL_CODE)
  `ASSERT_NEXT(a_bad_radix, clk, rst, in_valid && in_ready && bad_radix, out_valid && empty_res)

endmodule

bind signed_integer_to_radix_text_unit sitr_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .radix       (in_ch.radix),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .char_code   (out_ch.char_code),
  .in_alphabet (out_ch.in_alphabet),
  .last        (out_ch.last),
  .empty_res   (out_ch.empty_res)
);

// ===== tb/sv/signed_integer_to_radix_text_unit_tb.sv =====
`timescale 1ns / 1ps

module signed_integer_to_radix_text_unit_tb;

  localparam int VALUE_W   = sitr_pkg::VALUE_W;
  localparam int RADIX_W   = sitr_pkg::RADIX_W;
  localparam int CODE_W    = sitr_pkg::CODE_W;
  localparam int RADIX_MIN = sitr_pkg::RADIX_MIN;
  localparam int RADIX_MAX = sitr_pkg::RADIX_MAX;
  localparam int ALPHA_LEN = sitr_pkg::ALPHA_LEN;

  localparam logic [CODE_W-1:0] NULL_CODE  = sitr_pkg::NULL_CODE;
  localparam logic [CODE_W-1:0] MINUS_CODE = sitr_pkg::MINUS_CODE;

  localparam int MAX_TXT      = sitr_pkg::DEF_MAX_CHARS;
  localparam int RAND_ITEMS   = 285;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              in_alpha;
    logic              last;
    logic              empty;
  } char_exp_t;

  typedef enum logic [1:0] {BY_MODEL, BY_TEXT, BY_EMPTY} chk_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
    chk_t                      kind;
    string                     txt;
  } stim_row_t;

  localparam char_exp_t EMPTY_RES = '{code: NULL_CODE, in_alpha: 1'b0, last: 1'b1,
                                      empty: 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sitr_in_if  in_ch ();
  sitr_out_if out_ch ();

  signed_integer_to_radix_text_unit #(
    .MAX_CHARS(MAX_TXT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  char_exp_t pending_chars[$];
  stim_row_t stim_table[$];
  int        err_cnt     = 0;
  int        burst_left  = 0;
  int        n_values    = 0;
  int        n_negative  = 0;
  int        n_chars     = 0;
  int        n_empty     = 0;
  int        n_flagged   = 0;
  int        cycle_cnt   = 0;

  function automatic char_exp_t digit_sym(input logic [RADIX_W-1:0] d);
    char_exp_t c;
    string     punct;
    // backtick held as a space in the literal
    punct = "!#$%&()*+,-./:;<=>?@[]^_ {|}~";
    c = '{code: NULL_CODE, in_alpha: 1'b1, last: 1'b0, empty: 1'b0};
    if (d < 10) begin
      c.code = CODE_W'(d + 48);
    end else if (d < 36) begin
      c.code = CODE_W'(d + 55);
    end else if (d < 62) begin
      c.code = CODE_W'(d + 61);
    end else if (d < ALPHA_LEN) begin
      c.code = (punct[d - 62] == " ") ? 7'd96 : CODE_W'(punct[d - 62]);
    end else begin
      c.in_alpha = 1'b0;
    end
    return c;
  endfunction

  function automatic void predict_text(input logic signed [VALUE_W-1:0] v,
                                       input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] digs [MAX_TXT];
    char_exp_t          txt[$];
    char_exp_t          c;
    int                 nd;
    nd = 0;
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      pending_chars.push_back(EMPTY_RES);
      return;
    end
    if (v == 0) begin
      c = digit_sym(8'd0);
      c.last = 1'b1;
      pending_chars.push_back(c);
      return;
    end
    mag = v[VALUE_W-1] ? -v : v;
    while (mag != 0 && nd < MAX_TXT) begin
      digs[nd] = RADIX_W'(mag % r);
      mag      = mag / r;
      nd++;
    end
    if (v[VALUE_W-1]) begin
      txt.push_back('{code: MINUS_CODE, in_alpha: 1'b1, last: 1'b0, empty: 1'b0});
    end
    for (int i = nd - 1; i >= 0 && txt.size() < MAX_TXT; i--) begin
      txt.push_back(digit_sym(digs[i]));
    end
    txt[txt.size() - 1].last = 1'b1;
    foreach (txt[i]) pending_chars.push_back(txt[i]);
  endfunction

  function automatic void expect_literal(input string s);
    char_exp_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = '{code: CODE_W'(s[i]), in_alpha: 1'b1, last: (i == s.len() - 1), empty: 1'b0};
      pending_chars.push_back(c);
    end
  endfunction

  task automatic add_row(input logic signed [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                         input chk_t kind, input string txt);
    stim_table.push_back('{value: v, radix: r, kind: kind, txt: txt});
  endtask

  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                            input chk_t kind, input string txt);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.radix <= r;
    do @(posedge clk); while (!in_ch.ready);
    n_values++;
    if (v < 0) n_negative++;
    case (kind)
      BY_TEXT:  expect_literal(txt);
      BY_EMPTY: pending_chars.push_back(EMPTY_RES);
      default:  predict_text(v, r);
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] raw;
    int                 k;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       raw = '0;
          1:       raw = 64'd1;
          2:       raw = '1;
          3:       raw = VAL_MAX;
          default: raw = VAL_MIN;
        endcase
      end
      1, 2, 3: begin
        k   = $urandom_range(1, 20);
        raw = raw & ((64'd1 << k) - 64'd1);
        if ($urandom_range(0, 1) == 1) raw = -raw;
      end
      4, 5, 6: begin
        k   = $urandom_range(1, 63);
        raw = raw & ((64'd1 << k) - 64'd1);
        if ($urandom_range(0, 1) == 1) raw = -raw;
      end
      default: ;
    endcase
    return raw;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    logic [RADIX_W-1:0] r;
    case ($urandom_range(0, 19))
      0, 1: begin
        if ($urandom_range(0, 1) == 1) r = RADIX_W'($urandom_range(0, RADIX_MIN - 1));
        else r = RADIX_W'($urandom_range(RADIX_MAX + 1, 255));
      end
      2, 3, 4, 5, 6, 7:       r = RADIX_W'($urandom_range(RADIX_MIN, 16));
      8, 9, 10, 11, 12, 13:   r = RADIX_W'($urandom_range(17, ALPHA_LEN - 1));
      default:                r = RADIX_W'($urandom_range(ALPHA_LEN, RADIX_MAX));
    endcase
    return r;
  endfunction

  task automatic field_ok(input string name, input logic [CODE_W-1:0] want,
                          input logic [CODE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_chars
    char_exp_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_chars++;
      if (out_ch.empty_res === 1'b1) n_empty++;
      if (out_ch.in_alphabet === 1'b0 && out_ch.empty_res === 1'b0) n_flagged++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual code %0d", $time,
                 out_ch.char_code);
        err_cnt++;
      end else begin
        want = pending_chars.pop_front();
        field_ok("char_code", want.code, out_ch.char_code);
        field_ok("in_alphabet", CODE_W'(want.in_alpha), CODE_W'(out_ch.in_alphabet));
        field_ok("last", CODE_W'(want.last), CODE_W'(out_ch.last));
        field_ok("empty_res", CODE_W'(want.empty), CODE_W'(out_ch.empty_res));
      end
    end
  end

  initial begin : sink_stalls
    logic [15:0] mask;
    int          phase_left;
    int          pos;
    phase_left = 0;
    pos        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        mask       = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        phase_left = $urandom_range(16, 200);
      end
      out_ch.ready <= mask[pos];
      pos = (pos + 1) % 16;
      phase_left--;
    end
  end

  initial begin : watchdog
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk);
    $display("%0t: timeout with %0d transactions still expected", $time, pending_chars.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.radix <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(64'sd0,     8'd10,  BY_TEXT,  "0");
    add_row(64'sd7,     8'd0,   BY_EMPTY, "");
    add_row(64'sd7,     8'd1,   BY_EMPTY, "");
    add_row(-64'sd7,    8'd225, BY_EMPTY, "");
    add_row(VAL_MAX,    8'd255, BY_EMPTY, "");
    add_row(64'sd1,     8'd2,   BY_TEXT,  "1");
    add_row(-64'sd1,    8'd10,  BY_TEXT,  "-1");
    add_row(64'sd255,   8'd16,  BY_TEXT,  "FF");
    add_row(64'sd35,    8'd36,  BY_TEXT,  "Z");
    add_row(64'sd61,    8'd62,  BY_TEXT,  "z");
    add_row(64'sd62,    8'd91,  BY_TEXT,  "!");
    add_row(64'sd90,    8'd91,  BY_TEXT,  "~");
    add_row(-64'sd90,   8'd224, BY_TEXT,  "-~");
    add_row(64'sd91,    8'd92,  BY_MODEL, "");
    add_row(64'sd223,   8'd224, BY_MODEL, "");
    add_row(-64'sd200,  8'd224, BY_MODEL, "");
    add_row(VAL_MAX,    8'd2,   BY_TEXT,  "111111111111111");
    add_row(VAL_MIN,    8'd2,   BY_TEXT,  "-00000000000000");
    add_row(VAL_MAX,    8'd10,  BY_MODEL, "");
    add_row(VAL_MIN,    8'd10,  BY_MODEL, "");
    add_row(VAL_MAX,    8'd224, BY_MODEL, "");
    add_row(VAL_MIN,    8'd224, BY_MODEL, "");
    add_row(-64'sd999999999999999, 8'd10, BY_TEXT, "-99999999999999");
    add_row(64'sd99999999999999,   8'd10, BY_TEXT, "99999999999999");
    add_row(VAL_MIN,    8'd16,  BY_MODEL, "");

    foreach (stim_table[i]) begin
      send_value(stim_table[i].value, stim_table[i].radix, stim_table[i].kind,
                 stim_table[i].txt);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) begin
        // hold off until the output side has fully drained
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
        burst_left = 0;
      end
      send_value(pick_value(), pick_radix(), BY_MODEL, "");
    end
    in_ch.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d values (%0d negative) over %0d cycles with random gaps and stalls.",
             n_values, n_negative, cycle_cnt);
    $display("Checked %0d characters: %0d empty results, %0d digits outside the alphabet.",
             n_chars, n_empty, n_flagged);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
